FILE: hw/rtl/qoi_stream_decoder_assert.svh
// Assertion macros for the checker file.
`ifndef QOI_STREAM_DECODER_ASSERT_SVH
`define QOI_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define QSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define QSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/qsd_pkg.sv
`timescale 1ns / 1ps

package qsd_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_END   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [1:0] STAT_PIXEL     = 2'd0;
    localparam logic [1:0] STAT_END_MARK  = 2'd1;
    localparam logic [1:0] STAT_END_CLEAN = 2'd2;
    localparam logic [1:0] STAT_END_TRUNC = 2'd3;

    localparam logic [7:0] OP_RGB  = 8'hfe;
    localparam logic [7:0] OP_RGBA = 8'hff;

    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic [2:0] ZC_MAX = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_APPLY,
        ST_STORE,
        ST_BLEND,
        ST_EMIT_PX,
        ST_EMIT_ST
    } state_t;

    typedef struct packed {
        logic       in_ready;
        logic       clear_all;
        logic       take_pay;
        logic       open_op;
        logic       zc_inc;
        logic       zc_clr;
        logic       set_fin;
        logic       st_load;
        logic [1:0] st_code;
        logic       mem_rd;
        logic       load_lookup;
        logic       apply_diff;
        logic       apply_pay;
        logic       store;
        logic       blend;
        logic       load_run;
        logic       out_pixel;
        logic       out_status;
    } qsd_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] op;
        logic       fin;
        logic       pc_nz;
        logic       pc_one;
        logic [2:0] zc;
        logic       out_free;
        logic       run_zero;
    } qsd_sts_t;

endpackage

FILE: hw/rtl/qsd_ctrl.sv
`timescale 1ns / 1ps

module qsd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  qsd_pkg::qsd_sts_t sts,
    output qsd_pkg::qsd_cmd_t cmd
);

    qsd_pkg::state_t state_reg;
    qsd_pkg::state_t state_next;

    logic [1:0] tag;
    logic       is_rgb_op;
    logic       zero_first;
    logic       zero_repeat;
    logic       end_mark;

    assign tag         = sts.op[7:6];
    assign is_rgb_op   = (sts.op == qsd_pkg::OP_RGB) || (sts.op == qsd_pkg::OP_RGBA);
    assign zero_repeat = (sts.op == 8'd0) && (sts.zc != qsd_pkg::ZC_MAX);
    assign zero_first  = zero_repeat && (sts.zc == 3'd0);
    assign end_mark    = (sts.op == 8'd1) && (sts.zc == qsd_pkg::ZC_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qsd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = qsd_pkg::ST_DECODE;
                end
            end
            qsd_pkg::ST_DECODE:
            begin
                if (sts.kind == qsd_pkg::KIND_START || sts.kind == qsd_pkg::KIND_NONE
                    || sts.fin)
                begin
                    state_next = qsd_pkg::ST_IDLE;
                end
                else if (sts.kind == qsd_pkg::KIND_END)
                begin
                    state_next = qsd_pkg::ST_EMIT_ST;
                end
                else if (sts.pc_nz)
                begin
                    state_next = sts.pc_one ? qsd_pkg::ST_APPLY : qsd_pkg::ST_IDLE;
                end
                else if (is_rgb_op)
                begin
                    state_next = qsd_pkg::ST_IDLE;
                end
                else
                begin
                    unique case (tag)
                        qsd_pkg::TAG_INDEX:
                        begin
                            if (zero_repeat)
                            begin
                                state_next = zero_first ? qsd_pkg::ST_LOOKUP
                                                        : qsd_pkg::ST_IDLE;
                            end
                            else if (end_mark)
                            begin
                                state_next = qsd_pkg::ST_EMIT_ST;
                            end
                            else
                            begin
                                state_next = qsd_pkg::ST_LOOKUP;
                            end
                        end
                        qsd_pkg::TAG_DIFF: state_next = qsd_pkg::ST_STORE;
                        qsd_pkg::TAG_LUMA: state_next = qsd_pkg::ST_IDLE;
                        qsd_pkg::TAG_RUN:  state_next = qsd_pkg::ST_BLEND;
                        default:           state_next = qsd_pkg::ST_IDLE;
                    endcase
                end
            end
            qsd_pkg::ST_LOOKUP: state_next = qsd_pkg::ST_STORE;
            qsd_pkg::ST_APPLY:  state_next = qsd_pkg::ST_STORE;
            qsd_pkg::ST_STORE:  state_next = qsd_pkg::ST_BLEND;
            qsd_pkg::ST_BLEND:  state_next = qsd_pkg::ST_EMIT_PX;
            qsd_pkg::ST_EMIT_PX:
            begin
                if (sts.out_free && sts.run_zero)
                begin
                    state_next = qsd_pkg::ST_IDLE;
                end
            end
            qsd_pkg::ST_EMIT_ST:
            begin
                if (sts.out_free)
                begin
                    state_next = qsd_pkg::ST_IDLE;
                end
            end
            default: state_next = qsd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            qsd_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            qsd_pkg::ST_DECODE:
            begin
                if (sts.kind == qsd_pkg::KIND_START)
                begin
                    cmd.clear_all = 1'b1;
                end
                else if (sts.kind == qsd_pkg::KIND_NONE || sts.fin)
                begin
                    cmd.clear_all = 1'b0;
                end
                else if (sts.kind == qsd_pkg::KIND_END)
                begin
                    cmd.set_fin = 1'b1;
                    cmd.st_load = 1'b1;
                    cmd.st_code = sts.pc_nz ? qsd_pkg::STAT_END_TRUNC
                                            : qsd_pkg::STAT_END_CLEAN;
                end
                else if (sts.pc_nz)
                begin
                    cmd.take_pay = 1'b1;
                end
                else if (is_rgb_op)
                begin
                    cmd.open_op = 1'b1;
                    cmd.zc_clr  = 1'b1;
                end
                else
                begin
                    unique case (tag)
                        qsd_pkg::TAG_INDEX:
                        begin
                            if (zero_repeat)
                            begin
                                cmd.zc_inc = 1'b1;
                                cmd.mem_rd = zero_first;
                            end
                            else if (end_mark)
                            begin
                                cmd.set_fin = 1'b1;
                                cmd.st_load = 1'b1;
                                cmd.st_code = qsd_pkg::STAT_END_MARK;
                            end
                            else
                            begin
                                cmd.zc_clr = 1'b1;
                                cmd.mem_rd = 1'b1;
                            end
                        end
                        qsd_pkg::TAG_DIFF:
                        begin
                            cmd.apply_diff = 1'b1;
                            cmd.zc_clr     = 1'b1;
                        end
                        qsd_pkg::TAG_LUMA:
                        begin
                            cmd.open_op = 1'b1;
                            cmd.zc_clr  = 1'b1;
                        end
                        qsd_pkg::TAG_RUN:
                        begin
                            cmd.load_run = 1'b1;
                            cmd.zc_clr   = 1'b1;
                        end
                        default: cmd.zc_clr = 1'b0;
                    endcase
                end
            end
            qsd_pkg::ST_LOOKUP:  cmd.load_lookup = 1'b1;
            qsd_pkg::ST_APPLY:   cmd.apply_pay   = 1'b1;
            qsd_pkg::ST_STORE:   cmd.store       = 1'b1;
            qsd_pkg::ST_BLEND:   cmd.blend       = 1'b1;
            qsd_pkg::ST_EMIT_PX: cmd.out_pixel   = sts.out_free;
            qsd_pkg::ST_EMIT_ST: cmd.out_status  = sts.out_free;
            default:             cmd             = '0;
        endcase
    end

endmodule

FILE: hw/rtl/qsd_datapath.sv
`timescale 1ns / 1ps

module qsd_datapath
#(
    parameter int INDEX_ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_axis_tvalid,
    input  logic [7:0]        s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  qsd_pkg::qsd_cmd_t cmd,
    output qsd_pkg::qsd_sts_t sts
);

    localparam int AW = $clog2(INDEX_ENTRIES);

    logic              has_alpha_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        op_reg;
    logic [7:0]        r_reg;
    logic [7:0]        g_reg;
    logic [7:0]        b_reg;
    logic [7:0]        a_reg;
    logic [7:0]        pend_reg;
    logic [31:0]       pay_reg;
    logic [2:0]        pcnt_reg;
    logic [2:0]        zc_reg;
    logic              fin_reg;
    logic [5:0]        run_reg;
    logic [1:0]        code_reg;
    logic [15:0]       vr_reg;
    logic [15:0]       vg_reg;
    logic [15:0]       vb_reg;
    logic [31:0]       rd_q_reg;
    logic              rd_vld_reg;
    logic [INDEX_ENTRIES-1:0] idx_vld_reg;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;
    logic [1:0]        m_user_reg;
    logic              m_last_reg;

    logic [31:0]       idx_mem [INDEX_ENTRIES];

    logic [12:0]       hash_sum;
    logic [AW-1:0]     hash_idx;
    logic [AW-1:0]     rd_idx;
    logic [7:0]        diff_r;
    logic [7:0]        diff_g;
    logic [7:0]        diff_b;
    logic [7:0]        luma_r;
    logic [7:0]        luma_g;
    logic [7:0]        luma_b;
    logic [7:0]        luma_vg;
    logic [23:0]       pix_data;
    logic              out_free;
    logic              accept;

    function automatic logic [15:0] blend_sum(input logic [7:0] c, input logic [7:0] a);
        logic [7:0]  na;
        logic [16:0] t;
        na = 8'd255 - a;
        t  = {1'b0, na, 8'h00} - {9'h000, na} + {1'b0, 16'(a) * 16'(c)};
        return t[15:0];
    endfunction

    // exact floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [15:0] t;
        t = v + 16'd1 + {8'h00, v[15:8]};
        return t[15:8];
    endfunction

    assign accept   = s_axis_tvalid && cmd.in_ready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign hash_sum = 13'(r_reg) * 13'd3 + 13'(g_reg) * 13'd5
                    + 13'(b_reg) * 13'd7 + 13'(a_reg) * 13'd11;
    assign hash_idx = hash_sum[AW-1:0];
    assign rd_idx   = op_reg[AW-1:0];

    assign diff_r = 8'(r_reg + {6'd0, op_reg[5:4]} + 8'd254);
    assign diff_g = 8'(g_reg + {6'd0, op_reg[3:2]} + 8'd254);
    assign diff_b = 8'(b_reg + {6'd0, op_reg[1:0]} + 8'd254);

    assign luma_vg = {2'b00, pend_reg[5:0]};
    assign luma_g  = 8'(g_reg + luma_vg + 8'd224);
    assign luma_r  = 8'(r_reg + luma_vg + {4'd0, pay_reg[7:4]} + 8'd216);
    assign luma_b  = 8'(b_reg + luma_vg + {4'd0, pay_reg[3:0]} + 8'd216);

    assign pix_data = has_alpha_reg ? {div255(vb_reg), div255(vg_reg), div255(vr_reg)}
                                    : {b_reg, g_reg, r_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_alpha_reg <= 1'b0;
            r_reg         <= 8'd0;
            g_reg         <= 8'd0;
            b_reg         <= 8'd0;
            a_reg         <= 8'd255;
            pend_reg      <= 8'd0;
            pay_reg       <= 32'd0;
            pcnt_reg      <= 3'd0;
            zc_reg        <= 3'd0;
            fin_reg       <= 1'b0;
            run_reg       <= 6'd0;
            idx_vld_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                has_alpha_reg <= cfg_wr_data;
            end
            if (cmd.clear_all)
            begin
                r_reg       <= 8'd0;
                g_reg       <= 8'd0;
                b_reg       <= 8'd0;
                a_reg       <= 8'd255;
                pend_reg    <= 8'd0;
                pay_reg     <= 32'd0;
                pcnt_reg    <= 3'd0;
                zc_reg      <= 3'd0;
                fin_reg     <= 1'b0;
                run_reg     <= 6'd0;
                idx_vld_reg <= '0;
            end
            if (cmd.take_pay)
            begin
                pay_reg  <= {pay_reg[23:0], op_reg};
                pcnt_reg <= pcnt_reg - 3'd1;
            end
            if (cmd.open_op)
            begin
                pend_reg <= op_reg;
                pay_reg  <= 32'd0;
                if (op_reg == qsd_pkg::OP_RGBA)
                begin
                    pcnt_reg <= 3'd4;
                end
                else if (op_reg == qsd_pkg::OP_RGB)
                begin
                    pcnt_reg <= 3'd3;
                end
                else
                begin
                    pcnt_reg <= 3'd1;
                end
            end
            if (cmd.zc_inc)
            begin
                zc_reg <= zc_reg + 3'd1;
            end
            if (cmd.zc_clr)
            begin
                zc_reg <= 3'd0;
            end
            if (cmd.set_fin)
            begin
                fin_reg <= 1'b1;
            end
            if (cmd.load_lookup)
            begin
                {r_reg, g_reg, b_reg, a_reg} <= rd_vld_reg ? rd_q_reg : 32'd0;
            end
            if (cmd.apply_diff)
            begin
                r_reg <= diff_r;
                g_reg <= diff_g;
                b_reg <= diff_b;
            end
            if (cmd.apply_pay)
            begin
                if (pend_reg == qsd_pkg::OP_RGBA)
                begin
                    {r_reg, g_reg, b_reg, a_reg} <= pay_reg;
                end
                else if (pend_reg == qsd_pkg::OP_RGB)
                begin
                    {r_reg, g_reg, b_reg} <= pay_reg[23:0];
                end
                else
                begin
                    r_reg <= luma_r;
                    g_reg <= luma_g;
                    b_reg <= luma_b;
                end
                pend_reg <= 8'd0;
                pay_reg  <= 32'd0;
            end
            if (cmd.store)
            begin
                idx_vld_reg[hash_idx] <= 1'b1;
            end
            if (cmd.load_run)
            begin
                run_reg <= op_reg[5:0];
            end
            if (cmd.out_pixel && run_reg != 6'd0)
            begin
                run_reg <= run_reg - 6'd1;
            end
            if (cmd.out_pixel || cmd.out_status)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            op_reg   <= s_axis_tdata;
        end
        if (cmd.st_load)
        begin
            code_reg <= cmd.st_code;
        end
        if (cmd.mem_rd)
        begin
            rd_q_reg   <= idx_mem[rd_idx];
            rd_vld_reg <= idx_vld_reg[rd_idx];
        end
        if (cmd.store)
        begin
            idx_mem[hash_idx] <= {r_reg, g_reg, b_reg, a_reg};
        end
        if (cmd.blend)
        begin
            vr_reg <= blend_sum(r_reg, a_reg);
            vg_reg <= blend_sum(g_reg, a_reg);
            vb_reg <= blend_sum(b_reg, a_reg);
        end
        if (cmd.out_pixel)
        begin
            m_data_reg <= pix_data;
            m_user_reg <= qsd_pkg::STAT_PIXEL;
            m_last_reg <= (run_reg == 6'd0);
        end
        else if (cmd.out_status)
        begin
            m_data_reg <= 24'd0;
            m_user_reg <= code_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    assign sts.kind     = kind_reg;
    assign sts.op       = op_reg;
    assign sts.fin      = fin_reg;
    assign sts.pc_nz    = (pcnt_reg != 3'd0);
    assign sts.pc_one   = (pcnt_reg == 3'd1);
    assign sts.zc       = zc_reg;
    assign sts.out_free = out_free;
    assign sts.run_zero = (run_reg == 6'd0);

endmodule

FILE: hw/rtl/qoi_stream_decoder.sv
`timescale 1ns / 1ps

// QOI chunk-stream decoder. Takes the chunk bytes after the file header, one
// byte per input beat, and returns RGB pixels, optionally blended over white
// by alpha. Input is taken only while the controller is idle. A byte with no
// pixel goes from decode back to idle; DIFF goes to store, blend and emit;
// INDEX first reads the index memory (the read is registered), and the last
// payload byte of RGB, RGBA or LUMA is applied first. A RUN blends and emits
// all its pixels; status beats go to emit. Output beats wait for downstream
// ready. A start beat clears the color index through per-entry valid flags.
module qoi_stream_decoder
#(
    parameter int INDEX_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // has_alpha
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,    // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic [1:0]  m_axis_tuser,    // [1:0] status
    output logic        m_axis_tlast     // last_of_run
);

    qsd_pkg::qsd_cmd_t cmd;
    qsd_pkg::qsd_sts_t sts;

    qsd_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .sts           (sts),
        .cmd           (cmd)
    );

    qsd_datapath
    #(
        .INDEX_ENTRIES (INDEX_ENTRIES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

FILE: hw/rtl/qsd_checker.sv
`timescale 1ns / 1ps

`include "qoi_stream_decoder_assert.svh"

module qsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `QSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed while stalled")
    `QSD_ASSERT_NOW(a_status_beat, m_axis_tvalid && m_axis_tuser != qsd_pkg::STAT_PIXEL, m_axis_tdata == 24'd0 && m_axis_tlast, "status beat must be last with zero color")
    `QSD_ASSERT_NEXT(a_one_byte, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken on back-to-back cycles")

endmodule

bind qoi_stream_decoder qsd_checker u_qsd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 12;
    localparam logic [7:0]  OP_INDEX0      = 8'h00;
    localparam logic [7:0]  OP_END_MARK    = 8'h01;

    typedef struct packed {
        qsd_pkg::kind_t kind;
        logic [7:0]     data;
    } beat_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [1:0] status;
        logic       last;
    } pixel_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue
    logic [1:0]  m_axis_tuser;         // [1:0] status
    logic        m_axis_tlast;

    beat_t       byte_q[$];
    pixel_t      pixel_exp_q[$];
    beat_t       next_beat;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fed_count;
    int          err_cnt        = 0;
    int          quiet_cycles;

    // decoder shadow state
    rgba_t       palette[64];
    rgba_t       cur_px;
    logic [7:0]  pend_op;
    logic [31:0] pay_bytes;
    logic [2:0]  pay_left;
    logic [2:0]  zero_cnt;
    logic        img_done;
    logic        alpha_on;

    qoi_stream_decoder #(
        .INDEX_ENTRIES (64)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= 100)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ---------------- predictor ----------------

    task automatic clear_image();
        foreach (palette[i])
            palette[i] = '0;
        cur_px    = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
        pend_op   = '0;
        pay_bytes = '0;
        pay_left  = '0;
        zero_cnt  = '0;
        img_done  = 1'b0;
    endtask

    function automatic logic [5:0] palette_slot(input rgba_t p);
        int unsigned s;
        s = p.r * 32'd3 + p.g * 32'd5 + p.b * 32'd7 + p.a * 32'd11;
        return 6'(s % 64);
    endfunction

    function automatic logic [7:0] over_white(input logic [7:0] c, input logic [7:0] a);
        int unsigned cc;
        int unsigned aa;
        int unsigned v;
        cc = c;
        aa = a;
        v  = 255 * (255 - aa) + aa * cc;
        return 8'(v / 255);
    endfunction

    task automatic expect_pixel(input logic last);
        pixel_t p;
        if (alpha_on)
        begin
            p.r = over_white(cur_px.r, cur_px.a);
            p.g = over_white(cur_px.g, cur_px.a);
            p.b = over_white(cur_px.b, cur_px.a);
        end
        else
        begin
            p.r = cur_px.r;
            p.g = cur_px.g;
            p.b = cur_px.b;
        end
        p.status = qsd_pkg::STAT_PIXEL;
        p.last   = last;
        pixel_exp_q.push_back(p);
    endtask

    task automatic expect_status(input logic [1:0] code);
        pixel_t p;
        p        = '0;
        p.status = code;
        p.last   = 1'b1;
        pixel_exp_q.push_back(p);
    endtask

    task automatic store_and_expect();
        palette[palette_slot(cur_px)] = cur_px;
        expect_pixel(1'b1);
    endtask

    task automatic complete_payload();
        logic [7:0] vg;
        if (pend_op == qsd_pkg::OP_RGBA)
            cur_px = pay_bytes;
        else if (pend_op == qsd_pkg::OP_RGB)
            {cur_px.r, cur_px.g, cur_px.b} = pay_bytes[23:0];
        else
        begin
            vg       = {2'b00, pend_op[5:0]};
            cur_px.g = cur_px.g + vg + 8'd224;
            cur_px.r = cur_px.r + vg + {4'h0, pay_bytes[7:4]} + 8'd216;
            cur_px.b = cur_px.b + vg + {4'h0, pay_bytes[3:0]} + 8'd216;
        end
        pend_op   = '0;
        pay_bytes = '0;
        store_and_expect();
    endtask

    task automatic decode_byte(input logic [7:0] op);
        int n;
        if (pay_left != 0)
        begin
            pay_bytes = {pay_bytes[23:0], op};
            pay_left  = pay_left - 3'd1;
            if (pay_left == 0)
                complete_payload();
        end
        else if (op == qsd_pkg::OP_RGBA || op == qsd_pkg::OP_RGB)
        begin
            pend_op   = op;
            pay_bytes = '0;
            pay_left  = (op == qsd_pkg::OP_RGBA) ? 3'd4 : 3'd3;
            zero_cnt  = '0;
        end
        else
        begin
            case (op[7:6])
                qsd_pkg::TAG_INDEX:
                begin
                    if (op == OP_END_MARK && zero_cnt == qsd_pkg::ZC_MAX)
                    begin
                        img_done = 1'b1;
                        expect_status(qsd_pkg::STAT_END_MARK);
                    end
                    else
                    begin
                        if (op == OP_INDEX0 && zero_cnt < qsd_pkg::ZC_MAX)
                            zero_cnt = zero_cnt + 3'd1;
                        else
                            zero_cnt = '0;
                        // repeated INDEX(0) after the first is swallowed until zero_cnt reaches ZC_MAX
                        if (zero_cnt <= 3'd1)
                        begin
                            cur_px = palette[op[5:0]];
                            store_and_expect();
                        end
                    end
                end
                qsd_pkg::TAG_DIFF:
                begin
                    cur_px.r = cur_px.r + {6'd0, op[5:4]} + 8'd254;
                    cur_px.g = cur_px.g + {6'd0, op[3:2]} + 8'd254;
                    cur_px.b = cur_px.b + {6'd0, op[1:0]} + 8'd254;
                    zero_cnt = '0;
                    store_and_expect();
                end
                qsd_pkg::TAG_LUMA:
                begin
                    pend_op   = op;
                    pay_bytes = '0;
                    pay_left  = 3'd1;
                    zero_cnt  = '0;
                end
                default:
                begin
                    zero_cnt = '0;
                    n = op[5:0] + 1;
                    for (int k = 0; k < n; k++)
                        expect_pixel(k == n - 1);
                end
            endcase
        end
    endtask

    task automatic decode_beat(input beat_t bt);
        if (bt.kind == qsd_pkg::KIND_START)
            clear_image();
        else if (bt.kind == qsd_pkg::KIND_NONE || img_done)
            ;
        else if (bt.kind == qsd_pkg::KIND_END)
        begin
            img_done = 1'b1;
            expect_status((pay_left != 0) ? qsd_pkg::STAT_END_TRUNC
                                          : qsd_pkg::STAT_END_CLEAN);
        end
        else
            decode_byte(bt.data);
    endtask

    // ---------------- driver / monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_beat('{kind: qsd_pkg::kind_t'(s_axis_tuser), data: s_axis_tdata});
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat      = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.data;
                    s_axis_tuser  <= next_beat.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_pixel();
        pixel_t e;
        if (pixel_exp_q.size() == 0)
            report_error($sformatf("unexpected beat data=%h status=%0d last=%0d",
                                   m_axis_tdata, m_axis_tuser, m_axis_tlast));
        else
        begin
            e = pixel_exp_q.pop_front();
            if (m_axis_tdata[7:0] !== e.r)
                report_error($sformatf("red %h, want %h", m_axis_tdata[7:0], e.r));
            if (m_axis_tdata[15:8] !== e.g)
                report_error($sformatf("green %h, want %h", m_axis_tdata[15:8], e.g));
            if (m_axis_tdata[23:16] !== e.b)
                report_error($sformatf("blue %h, want %h", m_axis_tdata[23:16], e.b));
            if (m_axis_tuser !== e.status)
                report_error($sformatf("status %0d, want %0d", m_axis_tuser, e.status));
            if (m_axis_tlast !== e.last)
                report_error($sformatf("tlast %0d, want %0d", m_axis_tlast, e.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", quiet_cycles);
            $display("** qoi_stream_decoder: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- stimulus ----------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic push_beat(input qsd_pkg::kind_t k, input logic [7:0] d);
        byte_q.push_back('{kind: k, data: d});
        if (k != qsd_pkg::KIND_NONE)
            fed_count++;
    endtask

    task automatic push_byte(input logic [7:0] d);
        push_beat(qsd_pkg::KIND_BYTE, d);
    endtask

    task automatic push_op();
        int unsigned pick;
        logic [5:0]  low6;
        logic [7:0]  alpha;
        pick = $urandom_range(99);
        low6 = 6'($urandom_range(63));
        if (pick < 14)
        begin
            push_byte(qsd_pkg::OP_RGB);
            repeat (3) push_byte(rand_byte());
        end
        else if (pick < 26)
        begin
            push_byte(qsd_pkg::OP_RGBA);
            repeat (3) push_byte(rand_byte());
            case ($urandom_range(3))
                0:       alpha = 8'h00;
                1:       alpha = 8'hff;
                default: alpha = rand_byte();
            endcase
            push_byte(alpha);
        end
        else if (pick < 42)
            push_byte({qsd_pkg::TAG_INDEX, low6});
        else if (pick < 50)
            repeat ($urandom_range(1, 9)) push_byte(OP_INDEX0);
        else if (pick < 66)
            push_byte({qsd_pkg::TAG_DIFF, low6});
        else if (pick < 80)
        begin
            push_byte({qsd_pkg::TAG_LUMA, low6});
            push_byte(rand_byte());
        end
        else if (pick < 95)
            push_byte({qsd_pkg::TAG_RUN, 6'($urandom_range(0, 7))});
        else
            push_byte({qsd_pkg::TAG_RUN, 6'($urandom_range(8, 61))});
    endtask

    task automatic push_image();
        int unsigned pick;
        push_beat(qsd_pkg::KIND_START, rand_byte());
        repeat ($urandom_range(2, 10)) push_op();
        pick = $urandom_range(99);
        if (pick < 60)
            push_beat(qsd_pkg::KIND_END, rand_byte());
        else if (pick < 75)
        begin
            push_byte({qsd_pkg::TAG_DIFF, 6'($urandom_range(63))});
            repeat (7) push_byte(OP_INDEX0);
            push_byte(OP_END_MARK);
            if ($urandom_range(1))
                push_byte(rand_byte());
            push_beat(qsd_pkg::KIND_END, rand_byte());
        end
        else if (pick < 85)
        begin
            // cut off inside an op
            if ($urandom_range(1))
            begin
                push_byte(qsd_pkg::OP_RGBA);
                repeat ($urandom_range(0, 3)) push_byte(rand_byte());
            end
            else
                push_byte({qsd_pkg::TAG_LUMA, 6'($urandom_range(63))});
            push_beat(qsd_pkg::KIND_END, rand_byte());
        end
        else if (pick < 92)
        begin
            push_beat(qsd_pkg::KIND_NONE, rand_byte());
            push_beat(qsd_pkg::KIND_END, rand_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 4)) push_byte(rand_byte());
            push_beat(qsd_pkg::KIND_END, rand_byte());
        end
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || s_axis_tvalid || pixel_exp_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_alpha(input logic v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        alpha_on     = v;
        @(negedge clk);
    endtask

    initial
    begin
        clear_image();
        alpha_on       = 1'b0;
        send_idle_pct  = 11;
        recv_stall_pct = 62;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_alpha(1'b0);
        push_beat(qsd_pkg::KIND_START, 8'h00);
        repeat (7) push_byte(OP_INDEX0);
        push_byte(OP_END_MARK);
        push_byte(8'h55);
        push_beat(qsd_pkg::KIND_START, 8'hff);
        push_byte(qsd_pkg::OP_RGB);
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte({qsd_pkg::TAG_DIFF, 6'h00});
        push_byte({qsd_pkg::TAG_DIFF, 6'h3f});
        push_byte({qsd_pkg::TAG_LUMA, 6'h00});
        push_byte(8'h00);
        push_byte({qsd_pkg::TAG_LUMA, 6'h3f});
        push_byte(8'hff);
        push_byte({qsd_pkg::TAG_RUN, 6'h3d});
        push_beat(qsd_pkg::KIND_NONE, 8'ha5);
        push_beat(qsd_pkg::KIND_END, 8'h00);

        set_alpha(1'b1);
        push_beat(qsd_pkg::KIND_START, 8'h00);
        push_byte(qsd_pkg::OP_RGBA);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(8'h56);
        push_byte(8'h80);
        push_byte({qsd_pkg::TAG_RUN, 6'h00});
        push_byte({qsd_pkg::TAG_LUMA, 6'h3f});
        push_beat(qsd_pkg::KIND_END, 8'h00);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_alpha(ph % 2 == 0);
            case (ph / 2)
                0:       begin send_idle_pct = 11; recv_stall_pct = 62; end
                1:       begin send_idle_pct = 62; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            fed_count = 0;
            while (fed_count < 22)
                push_image();
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (pixel_exp_q.size() != 0)
            report_error($sformatf("%0d expected beats never came", pixel_exp_q.size()));
        if (err_cnt == 0)
            $display("** qoi_stream_decoder: PASSED **");
        else
            $display("** qoi_stream_decoder: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/qsd_pkg.sv
hw/rtl/qsd_ctrl.sv
hw/rtl/qsd_datapath.sv
hw/rtl/qoi_stream_decoder.sv
hw/rtl/qsd_checker.sv
bench/tb_top.sv
